[rtl/sida_pkg.sv]
// shared types and constants for the signed integer to decimal text converter
package sida_pkg;

   localparam int VALUE_W   = 32;
   localparam int CHAR_W    = 8;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W     = 4 * NUM_DIGITS;
   localparam int IDX_W     = 4;
   localparam int CNT_W     = 5;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
   localparam logic [CNT_W-1:0]  LAST_SHIFT  = 5'd31;

   typedef struct packed {
      logic load;        // capture input and start conversion
      logic shift;       // one double-dabble step
      logic init_ptr;    // point at the most significant nonzero digit
      logic load_sign;   // put '-' into the output register
      logic load_digit;  // put the current digit into the output register
   } cmd_type;

   typedef struct packed {
      logic conv_done;   // this shift is the final one
      logic negative;    // captured value was negative
      logic out_free;    // output register can take a character
      logic digit_last;  // current digit is the least significant one
   } status_type;

endpackage

[rtl/sida_datapath.sv]
// datapath: magnitude, double-dabble digit register, digit pointer and output register
module sida_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [sida_pkg::VALUE_W-1:0] req_value,
   input  sida_pkg::cmd_type                   cmd,
   output sida_pkg::status_type                sts,
   output logic                                rsp_valid,
   output logic [sida_pkg::CHAR_W-1:0]         rsp_out_char,
   output logic                                rsp_last_char,
   input  logic                                rsp_stall
);
   import sida_pkg::*;

   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in, bcd_adj;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in, msd;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [3:0]         digit_cur;

   assign raw = $unsigned(req_value);

   // add-3 correction on every digit that is five or more
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // most significant nonzero digit, zero when all digits are zero
   always_comb begin
      msd = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            msd = IDX_W'(i);
         end
      end
   end

   assign digit_cur = bcd_ff[4*ptr_ff +: 4];

   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff & rsp_stall;
      if (cmd.load) begin
         neg_in = raw[VALUE_W-1];
         mag_in = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
         bcd_in = '0;
         cnt_in = '0;
      end
      if (cmd.shift) begin
         {bcd_in, mag_in} = {bcd_adj[BCD_W-2:0], mag_ff, 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.init_ptr) begin
         ptr_in = msd;
      end
      if (cmd.load_sign) begin
         char_in  = ASCII_MINUS;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end
      if (cmd.load_digit) begin
         char_in  = ASCII_ZERO + {4'd0, digit_cur};
         last_in  = (ptr_ff == '0);
         valid_in = 1'b1;
         ptr_in   = ptr_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      ptr_ff  <= ptr_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign sts.conv_done  = (cnt_ff == LAST_SHIFT);
   assign sts.negative   = neg_ff;
   assign sts.out_free   = ~valid_ff | ~rsp_stall;
   assign sts.digit_last = (ptr_ff == '0);

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

[rtl/sida_controller.sv]
// controller: sequences capture, conversion and character output
module sida_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output sida_pkg::cmd_type    cmd,
   input  sida_pkg::status_type sts
);
   import sida_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_SIGN = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.shift = 1'b1;
            if (sts.conv_done) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            cmd.init_ptr = 1'b1;
            if (!sts.negative) begin
               state_in = S_EMIT;
            end else if (sts.out_free) begin
               cmd.load_sign = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_digit = 1'b1;
               if (sts.digit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_starts_conv: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CONV)
      else $error("capture not followed by conversion");

   a_conv_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV && sts.conv_done) |=> state_ff == S_SIGN)
      else $error("conversion did not end after last shift");

   a_one_char: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_sign && cmd.load_digit))
      else $error("sign and digit loaded together");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_sign || cmd.load_digit) |-> sts.out_free)
      else $error("character loaded over a pending transfer");

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// top level: 32-bit signed integer to decimal ascii character stream
// Takes one 32-bit two's complement value per transfer on the req_ channel
// and sends its decimal text on the rsp_ channel, one ascii character per
// transfer, most significant first: a leading '-' for negative values, then
// the magnitude with no leading zeros (zero prints as '0', the most negative
// value prints as -2147483648). rsp_last_char marks the final character of
// each number. Each value passes through these steps in order: the value is
// captured, a double-dabble shift register then turns the binary magnitude
// into ten bcd digits one input bit per cycle, the sign step selects the
// leading digit and loads the '-' of a negative value, and the single output
// register then takes one digit per cycle while the receiver does not stall.
// The next value is taken as soon as the last character is in the output
// register.
module signed_int_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sida_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sida_pkg::CHAR_W-1:0]         rsp_out_char,
   output logic                                rsp_last_char
);
   import sida_pkg::*;

   // command and status between the sequencer and the datapath
   cmd_type    cmd;
   status_type sts;

   // sequencer: idle, conversion, sign, digit output
   sida_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // magnitude, bcd digits and the output register
   sida_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .rsp_stall     (rsp_stall)
   );

endmodule

[tb/sv/signed_int_to_decimal_ascii_tb.sv]
// self-checking testbench for the signed integer to decimal ascii converter
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
   import sida_pkg::*;

   localparam int RANDOM_VALUES = 440;
   // slowest value is a full conversion plus 11 heavily stalled characters
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 60;
   localparam int MODE_STRETCH  = 55;
   localparam int RADIX         = 10;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // one character of a decimal text run as the rsp_ channel carries it
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   // expected decimal text of every accepted value, oldest first
   class decimal_text_board;
      text_char_type pending_chars[$];
      int unsigned   values_seen;
      int unsigned   negatives_seen;
      int unsigned   chars_checked;
      int unsigned   mismatches;

      // turn an accepted value into its expected characters
      function void note_value(logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] magnitude;
         logic [3:0]         digit_lsb_first [NUM_DIGITS];
         int                 digit_count;
         text_char_type      item;
         magnitude   = value[VALUE_W-1] ? (~value + 1'b1) : value;
         digit_count = 0;
         do begin
            digit_lsb_first[digit_count] = 4'(magnitude % RADIX);
            digit_count++;
            magnitude = magnitude / RADIX;
         end while (magnitude != 0 && digit_count < NUM_DIGITS);
         values_seen++;
         if (value[VALUE_W-1]) begin
            negatives_seen++;
            item.code = ASCII_MINUS;
            item.last = 1'b0;
            pending_chars.push_back(item);
         end
         for (int k = digit_count - 1; k >= 0; k--) begin
            item.code = ASCII_ZERO + CHAR_W'(digit_lsb_first[k]);
            item.last = (k == 0);
            pending_chars.push_back(item);
         end
      endfunction

      // compare one received character with the oldest expected one
      function void check_char(logic [CHAR_W-1:0] code, logic last);
         text_char_type want;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected character %0d last %0b with nothing pending", code, last);
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (code !== want.code || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("character mismatch: expected %0d last %0b, got %0d last %0b",
                        want.code, want.last, code, last);
         end
      endfunction

      function bit clean();
         return mismatches == 0 && pending_chars.size() == 0;
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [CHAR_W-1:0]          rsp_out_char;
   logic                       rsp_last_char;

   decimal_text_board board;
   stall_mode_type    stall_mode;
   int unsigned       stall_phase;
   int unsigned       cycle_count;
   int                burst_left;
   bit                gaps_enabled;

   signed_int_to_decimal_ascii i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver back-pressure, pattern chosen by the current stall mode
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_phase % 7) < 3);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // every transfer is seen here, at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_value(req_value);
         if (rsp_valid && !rsp_stall)
            board.check_char(rsp_out_char, rsp_last_char);
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("signed_int_to_decimal_ascii test failed");
         $finish;
      end
   end

   // hold valid low for some cycles, with junk on the payload
   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_value <= $urandom();
      end
   endtask

   // offer one value and wait for its transfer
   task automatic send_value(input logic [VALUE_W-1:0] value);
      if (burst_left == 0) begin
         if (gaps_enabled && $urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 14));
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // random value, spread over all run lengths and both signs
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] magnitude;
      logic [VALUE_W-1:0] low_bound;
      logic [VALUE_W-1:0] decade;
      int                 digits;
      decade = 1;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: begin
            // uniform digit count, then a value with exactly that many digits
            digits = $urandom_range(1, NUM_DIGITS);
            for (int k = 1; k < digits; k++)
               decade = decade * RADIX;
            low_bound = (digits == 1) ? 0 : decade;
            if (digits == NUM_DIGITS)
               magnitude = $urandom_range(32'h7fff_ffff, low_bound);
            else
               magnitude = $urandom_range(decade * RADIX - 1, low_bound);
         end
         2: begin
            // just around a power of ten, where the digit count changes
            digits = $urandom_range(0, NUM_DIGITS - 1);
            for (int k = 0; k < digits; k++)
               decade = decade * RADIX;
            magnitude = decade + $urandom_range(0, 2) - 1;
         end
         default: magnitude = $urandom_range(0, 200);
      endcase
      if ($urandom_range(0, 1) == 1)
         magnitude = ~magnitude + 1'b1;
      return magnitude;
   endfunction

   initial begin
      int directed_values[$];
      directed_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                          999999999, -999999999, 1000000000, -1000000000,
                          1234567890, -1234567890, 2147483647, -2147483647,
                          32'sh8000_0000, 32'sh5555_5555, 32'shaaaa_aaaa};
      board        = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_value    = '0;
      rsp_stall    = 1'b0;
      stall_mode   = STALL_LIGHT;
      stall_phase  = 0;
      cycle_count  = 0;
      burst_left   = 0;
      gaps_enabled = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, short and full-length runs, zero and the most negative value
      foreach (directed_values[i])
         send_value(directed_values[i]);

      // random stretches, the first one with no idling on either side
      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n % MODE_STRETCH == 0) begin
            gaps_enabled = (n != 0);
            stall_mode   = (n == 0) ? STALL_NONE : stall_mode_type'($urandom_range(0, 3));
         end
         send_value(pick_value());
      end
      pause_sender(1);

      while (board.pending_chars.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("converted %0d values (%0d negative), checked %0d characters",
               board.values_seen, board.negatives_seen, board.chars_checked);
      $display("sender bursts with random gaps; receiver stalls none, random, periodic, heavy");
      if (board.pending_chars.size() != 0)
         $display("%0d characters never arrived", board.pending_chars.size());
      if (board.mismatches > 10)
         $display("%0d mismatches in total", board.mismatches);
      if (board.clean())
         $display("signed_int_to_decimal_ascii test passed");
      else
         $display("signed_int_to_decimal_ascii test failed");
      $finish;
   end

endmodule
